// ----- rtl/core/bqc_pkg.sv -----
// ----------------------------------------------------------------------------
// bqc_pkg
// Shared constants, register codes and control types for the biquad cascade.
// ----------------------------------------------------------------------------
`default_nettype none

package bqc_pkg;

  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int COEF_FRAC_BITS_DEF = 24;

  // Coefficient register width (Q2.24 by default)
  localparam int COEF_BITS = 27;
  // Serial accumulator: b1 = 2*b0 and five terms summed, plus headroom
  localparam int ACC_BITS  = COEF_BITS + 4;

  localparam int NUM_SECTIONS = 4;
  localparam int SEC_BITS     = 2;

  localparam int APB_ADDR_BITS = 5;
  localparam int APB_DATA_BITS = 32;
  localparam int REG_IDX_BITS  = 3;

  localparam logic [REG_IDX_BITS-1:0] REG_HP_B0 = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_HP_A1 = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_HP_A2 = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_LP_B0 = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_LP_A1 = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_LP_A2 = 3'd5;

  typedef struct packed {
    logic load;   // take operands and coefficients, clear accumulator
    logic step;   // one bit of every operand
    logic msb;    // current bit is the sign bit (negative weight)
    logic round;  // round and scale the finished sum
  } bqc_mac_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/bqc_serial_mac.sv -----
// ----------------------------------------------------------------------------
// bqc_serial_mac
// Bit-serial multiply-accumulate for one direct-form-I biquad section.
// Operands go LSB first; accumulator shifts right one bit a cycle on step.
// ----------------------------------------------------------------------------
`default_nettype none

module bqc_serial_mac #(
  parameter int SAMPLE_BITS    = bqc_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = bqc_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire                                  clk,
  input  bqc_pkg::bqc_mac_ctrl_t               ctrl,
  input  wire        [SAMPLE_BITS-1:0]         x,
  input  wire        [SAMPLE_BITS-1:0]         x1,
  input  wire        [SAMPLE_BITS-1:0]         x2,
  input  wire        [SAMPLE_BITS-1:0]         y1,
  input  wire        [SAMPLE_BITS-1:0]         y2,
  input  wire signed [bqc_pkg::COEF_BITS-1:0]  b0,
  input  wire signed [bqc_pkg::COEF_BITS-1:0]  a1,
  input  wire signed [bqc_pkg::COEF_BITS-1:0]  a2,
  input  wire                                  lowpass,
  output logic       [SAMPLE_BITS-1:0]         y,
  output logic                                 clip
);
  import bqc_pkg::*;

  localparam int FULL_BITS = ACC_BITS + SAMPLE_BITS;
  localparam int Q_BITS    = FULL_BITS - COEF_FRAC_BITS;

  localparam logic signed [ACC_BITS-1:0]  ZERO = '0;
  localparam logic signed [FULL_BITS-1:0] RND  =
    {{(FULL_BITS-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
  localparam logic signed [Q_BITS-1:0] Y_MAX =
    {{(Q_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [Q_BITS-1:0] Y_MIN =
    {{(Q_BITS-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

  logic        [SAMPLE_BITS-1:0] sx, sx1, sx2, sy1, sy2;
  logic signed [ACC_BITS-1:0]    b0_r, b1_r, a1_r, a2_r;
  logic signed [ACC_BITS-1:0]    acc_hi;
  logic        [SAMPLE_BITS-1:0] acc_lo;
  logic signed [Q_BITS-1:0]      q;

  logic signed [ACC_BITS-1:0]    b0_ext, b1_ext, partial, t;
  logic signed [FULL_BITS-1:0]   sum;

  assign b0_ext = ACC_BITS'(b0);
  assign b1_ext = lowpass ? (b0_ext <<< 1) : -(b0_ext <<< 1);

  // one bit of each operand selects its coefficient
  assign partial = (sx[0]  ? b0_r : ZERO) + (sx2[0] ? b0_r : ZERO)
                 + (sx1[0] ? b1_r : ZERO) - (sy1[0] ? a1_r : ZERO)
                 - (sy2[0] ? a2_r : ZERO);
  assign t   = ctrl.msb ? (acc_hi - partial) : (acc_hi + partial);
  assign sum = $signed({acc_hi, acc_lo}) + RND;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      sx     <= x;
      sx1    <= x1;
      sx2    <= x2;
      sy1    <= y1;
      sy2    <= y2;
      b0_r   <= b0_ext;
      b1_r   <= b1_ext;
      a1_r   <= ACC_BITS'(a1);
      a2_r   <= ACC_BITS'(a2);
      acc_hi <= '0;
      acc_lo <= '0;
    end else if (ctrl.step) begin
      sx     <= sx  >> 1;
      sx1    <= sx1 >> 1;
      sx2    <= sx2 >> 1;
      sy1    <= sy1 >> 1;
      sy2    <= sy2 >> 1;
      acc_hi <= t >>> 1;
      acc_lo <= {t[0], acc_lo[SAMPLE_BITS-1:1]};
    end
    if (ctrl.round) begin
      q <= sum[FULL_BITS-1:COEF_FRAC_BITS];
    end
  end

  always_comb begin
    clip = 1'b0;
    y    = q[SAMPLE_BITS-1:0];
    if (q > Y_MAX) begin
      y    = Y_MAX[SAMPLE_BITS-1:0];
      clip = 1'b1;
    end else if (q < Y_MIN) begin
      y    = Y_MIN[SAMPLE_BITS-1:0];
      clip = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/bqc_history.sv -----
// ----------------------------------------------------------------------------
// bqc_history
// Per-section delay lines: last two inputs and last two outputs.
// ----------------------------------------------------------------------------
`default_nettype none

module bqc_history #(
  parameter int SAMPLE_BITS = bqc_pkg::SAMPLE_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          clear,
  input  wire                          wr,
  input  wire  [bqc_pkg::SEC_BITS-1:0] sel,
  input  wire  [SAMPLE_BITS-1:0]       x_in,
  input  wire  [SAMPLE_BITS-1:0]       y_in,
  output logic [SAMPLE_BITS-1:0]       x1,
  output logic [SAMPLE_BITS-1:0]       x2,
  output logic [SAMPLE_BITS-1:0]       y1,
  output logic [SAMPLE_BITS-1:0]       y2
);
  import bqc_pkg::*;

  logic [SAMPLE_BITS-1:0] hx1 [NUM_SECTIONS];
  logic [SAMPLE_BITS-1:0] hx2 [NUM_SECTIONS];
  logic [SAMPLE_BITS-1:0] hy1 [NUM_SECTIONS];
  logic [SAMPLE_BITS-1:0] hy2 [NUM_SECTIONS];

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      for (int i = 0; i < NUM_SECTIONS; i++) begin
        hx1[i] <= '0;
        hx2[i] <= '0;
        hy1[i] <= '0;
        hy2[i] <= '0;
      end
    end else if (wr) begin
      hx2[sel] <= hx1[sel];
      hx1[sel] <= x_in;
      hy2[sel] <= hy1[sel];
      hy1[sel] <= y_in;
    end
  end

  assign x1 = hx1[sel];
  assign x2 = hx2[sel];
  assign y1 = hy1[sel];
  assign y2 = hy2[sel];

endmodule

`default_nettype wire

// ----- rtl/core/biquad_bandpass_cascade.sv -----
// ----------------------------------------------------------------------------
// biquad_bandpass_cascade
// Four direct-form-I biquads in series (two high-pass, two low-pass) on one
// shared bit-serial MAC. Each section runs load, then one bit per cycle,
// then round, then saturate and write history.
// A new sample is accepted only in idle, after the last result has gone to
// the single output register; that register frees the input side.
// Reset: synchronous; clears coefficients, all section history and control.
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_bandpass_cascade #(
  parameter int SAMPLE_BITS    = bqc_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = bqc_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  // stream in
  input  wire                                s_tvalid,
  output logic                               s_tready,
  input  wire  [((SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,   // [SAMPLE_BITS-1:0] sample_in
  input  wire                                s_tuser,   // [0] start_of_take
  // stream out
  output logic                               m_tvalid,
  input  wire                                m_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]   m_tdata,   // [SAMPLE_BITS-1:0] sample_out
  output logic                               m_tuser,   // [0] clipped
  // configuration
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [bqc_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  wire  [bqc_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [bqc_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                               pready
);
  import bqc_pkg::*;

  localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int CNT_BITS   = $clog2(SAMPLE_BITS);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(SAMPLE_BITS - 1);
  localparam logic [SEC_BITS-1:0] SEC_LAST = SEC_BITS'(NUM_SECTIONS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MAC,
    ST_ROUND,
    ST_SAT,
    ST_FINISH
  } state_t;

  function automatic logic [APB_DATA_BITS-1:0] sext_coef(logic [COEF_BITS-1:0] c);
    return {{(APB_DATA_BITS-COEF_BITS){c[COEF_BITS-1]}}, c};
  endfunction

  state_t                 state;
  logic [SEC_BITS-1:0]    sec;
  logic [CNT_BITS-1:0]    cnt;
  logic [SAMPLE_BITS-1:0] cur_x;
  logic                   clip_acc;

  logic [COEF_BITS-1:0] hp_b0, hp_a1, hp_a2, lp_b0, lp_a1, lp_a2;
  logic [REG_IDX_BITS-1:0] reg_idx;

  bqc_mac_ctrl_t          mac_ctrl;
  logic [SAMPLE_BITS-1:0] h_x1, h_x2, h_y1, h_y2;
  logic [SAMPLE_BITS-1:0] mac_y;
  logic                   mac_clip;
  logic                   lowpass;

  // ---- configuration registers ----
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_BITS-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      hp_b0 <= '0;
      hp_a1 <= '0;
      hp_a2 <= '0;
      lp_b0 <= '0;
      lp_a1 <= '0;
      lp_a2 <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_HP_B0: hp_b0 <= pwdata[COEF_BITS-1:0];
        REG_HP_A1: hp_a1 <= pwdata[COEF_BITS-1:0];
        REG_HP_A2: hp_a2 <= pwdata[COEF_BITS-1:0];
        REG_LP_B0: lp_b0 <= pwdata[COEF_BITS-1:0];
        REG_LP_A1: lp_a1 <= pwdata[COEF_BITS-1:0];
        REG_LP_A2: lp_a2 <= pwdata[COEF_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_HP_B0: prdata = sext_coef(hp_b0);
      REG_HP_A1: prdata = sext_coef(hp_a1);
      REG_HP_A2: prdata = sext_coef(hp_a2);
      REG_LP_B0: prdata = sext_coef(lp_b0);
      REG_LP_A1: prdata = sext_coef(lp_a1);
      REG_LP_A2: prdata = sext_coef(lp_a2);
      default:   prdata = '0;
    endcase
  end

  // ---- sequencer ----
  assign s_tready = (state == ST_IDLE);
  // sections 2 and 3 are the low-pass pair
  assign lowpass  = sec[SEC_BITS-1];

  assign mac_ctrl.load  = (state == ST_LOAD);
  assign mac_ctrl.step  = (state == ST_MAC);
  assign mac_ctrl.msb   = (cnt == CNT_LAST);
  assign mac_ctrl.round = (state == ST_ROUND);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      sec      <= '0;
      cnt      <= '0;
      clip_acc <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // in ST_FINISH the output slot is handled by the state itself
      if (m_tvalid && m_tready && state != ST_FINISH) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cur_x    <= s_tdata[SAMPLE_BITS-1:0];
            clip_acc <= 1'b0;
            sec      <= '0;
            state    <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          cnt   <= '0;
          state <= ST_MAC;
        end
        ST_MAC: begin
          if (cnt == CNT_LAST) begin
            state <= ST_ROUND;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_ROUND: begin
          state <= ST_SAT;
        end
        ST_SAT: begin
          cur_x    <= mac_y;
          clip_acc <= clip_acc | mac_clip;
          if (sec == SEC_LAST) begin
            state <= ST_FINISH;
          end else begin
            sec   <= sec + 1'b1;
            state <= ST_LOAD;
          end
        end
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= TDATA_BITS'(cur_x);
            m_tuser  <= clip_acc;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  bqc_history #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_history (
    .clk   (clk),
    .rst   (rst),
    .clear (s_tvalid && s_tready && s_tuser),
    .wr    (state == ST_SAT),
    .sel   (sec),
    .x_in  (cur_x),
    .y_in  (mac_y),
    .x1    (h_x1),
    .x2    (h_x2),
    .y1    (h_y1),
    .y2    (h_y2)
  );

  bqc_serial_mac #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_mac (
    .clk     (clk),
    .ctrl    (mac_ctrl),
    .x       (cur_x),
    .x1      (h_x1),
    .x2      (h_x2),
    .y1      (h_y1),
    .y2      (h_y2),
    .b0      (lowpass ? lp_b0 : hp_b0),
    .a1      (lowpass ? lp_a1 : hp_a1),
    .a2      (lowpass ? lp_a2 : hp_a2),
    .lowpass (lowpass),
    .y       (mac_y),
    .clip    (mac_clip)
  );

endmodule

`default_nettype wire

// ----- rtl/core/bqc_checker.sv -----
// ----------------------------------------------------------------------------
// bqc_checker
// Port-level checks on the biquad cascade, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bqc_checker #(
  parameter int SAMPLE_BITS = bqc_pkg::SAMPLE_BITS_DEF
) (
  input wire                               clk,
  input wire                               rst,
  input wire                               s_tvalid,
  input wire                               s_tready,
  input wire                               m_tvalid,
  input wire                               m_tready,
  input wire [((SAMPLE_BITS+7)/8)*8-1:0]   m_tdata,
  input wire                               m_tuser
);

  // one request at a time: input side closes straight after a request
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while previous request in progress");

  // a result never appears right after a request
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
    else $error("result appeared too soon after request");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

  // out of reset: idle, nothing pending
  a_reset_state: assert property (@(posedge clk)
    rst |=> (!m_tvalid && s_tready))
    else $error("block not idle after reset");

endmodule

bind biquad_bandpass_cascade bqc_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_bqc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
